/* rtl/core/lcl_pkg.sv */
// Shared types, constants and helpers for the LCL temperature pipeline.
// No dependencies; imported by every module in rtl/core.
package lcl_pkg;

  localparam int FracBits  = 24;
  localparam int LogSteps  = 24;
  localparam int QBits     = 17;
  localparam logic [15:0] KelvinOffset = 16'd27315;
  localparam logic signed [16:0] MinCelsius = -17'sd27315;
  localparam logic signed [30:0] Ln2Q30 = 31'sd744261118;
  localparam logic [16:0] BoltonA = 17'd80000;
  localparam logic signed [17:0] BoltonB = 18'sd5600;
  localparam logic signed [63:0] BoltonAQ = 64'sd1342177280000; // 80000 << 24

  // carried alongside the log lanes
  typedef struct packed {
    logic        miss;
    logic        last;
    logic [15:0] dk;
  } log_pass_t;

  // carried alongside the divider
  typedef struct packed {
    logic neg;
    logic miss;
    logic last;
  } div_side_t;

  // position of the leading one of a 16-bit value
  function automatic logic [3:0] lead_one(input logic [15:0] x);
    logic [3:0] e;
    e = '0;
    for (int i = 1; i < 16; i++) begin
      if (x[i]) e = 4'(i);
    end
    return e;
  endfunction

endpackage

/* rtl/core/lcl_log2_pipe.sv */
// Two-lane fixed-point log2 pipeline, Q24 output, one squaring per stage.
// Depends on lcl_pkg.
module lcl_log2_pipe (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  logic [15:0]        in_a,
  input  logic [15:0]        in_b,
  input  lcl_pkg::log_pass_t in_pass,
  output logic               out_valid,
  output logic [27:0]        out_la,
  output logic [27:0]        out_lb,
  output lcl_pkg::log_pass_t out_pass
);
  import lcl_pkg::*;

  logic            vld  [0:LogSteps];
  logic [30:0]     ma   [0:LogSteps];
  logic [30:0]     mb   [0:LogSteps];
  logic [27:0]     ra   [0:LogSteps];
  logic [27:0]     rb   [0:LogSteps];
  log_pass_t       pass [0:LogSteps];

  logic [3:0] ea, eb;
  assign ea = lead_one(in_a);
  assign eb = lead_one(in_b);

  // normalize mantissa to Q30 in [1,2)
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ma[0]   <= {15'd0, in_a} << (5'd30 - {1'b0, ea});
      mb[0]   <= {15'd0, in_b} << (5'd30 - {1'b0, eb});
      ra[0]   <= {ea, 24'd0};
      rb[0]   <= {eb, 24'd0};
      pass[0] <= in_pass;
    end
  end

  for (genvar i = 1; i <= LogSteps; i++) begin : g_step
    logic [61:0] pa, pb;
    logic [31:0] sa, sb;
    assign pa = {31'd0, ma[i-1]} * {31'd0, ma[i-1]};
    assign pb = {31'd0, mb[i-1]} * {31'd0, mb[i-1]};
    assign sa = pa[61:30];
    assign sb = pb[61:30];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (adv) begin
        vld[i] <= vld[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ma[i]   <= sa[31] ? sa[31:1] : sa[30:0];
        mb[i]   <= sb[31] ? sb[31:1] : sb[30:0];
        ra[i]   <= ra[i-1] | (28'(sa[31]) << (LogSteps - i));
        rb[i]   <= rb[i-1] | (28'(sb[31]) << (LogSteps - i));
        pass[i] <= pass[i-1];
      end
    end
  end

  assign out_valid = vld[LogSteps];
  assign out_la    = ra[LogSteps];
  assign out_lb    = rb[LogSteps];
  assign out_pass  = pass[LogSteps];

endmodule

/* rtl/core/lcl_div_pipe.sv */
// Restoring divider, one quotient bit per stage, with overflow stage up front.
// Depends on lcl_pkg.
module lcl_div_pipe (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  logic [63:0]        in_num,
  input  logic [63:0]        in_dsr,
  input  lcl_pkg::div_side_t in_side,
  output logic               out_valid,
  output logic               out_ovf,
  output logic [16:0]        out_q,
  output lcl_pkg::div_side_t out_side
);
  import lcl_pkg::*;

  logic        vld  [0:QBits];
  logic [63:0] rem  [0:QBits];
  logic [63:0] dsr  [0:QBits];
  logic [16:0] q    [0:QBits];
  logic        ovf  [0:QBits];
  div_side_t   side [0:QBits];

  // quotient would need more than QBits bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0]  <= in_num;
      dsr[0]  <= in_dsr;
      q[0]    <= '0;
      ovf[0]  <= in_num >= (in_dsr << QBits);
      side[0] <= in_side;
    end
  end

  for (genvar j = 1; j <= QBits; j++) begin : g_bit
    logic [63:0] t;
    logic        ge;
    assign t  = dsr[j-1] << (QBits - j);
    assign ge = rem[j-1] >= t;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (adv) begin
        vld[j] <= vld[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[j]  <= ge ? rem[j-1] - t : rem[j-1];
        dsr[j]  <= dsr[j-1];
        q[j]    <= q[j-1] | (17'(ge) << (QBits - j));
        ovf[j]  <= ovf[j-1];
        side[j] <= side[j-1];
      end
    end
  end

  assign out_valid = vld[QBits];
  assign out_ovf   = ovf[QBits];
  assign out_q     = q[QBits];
  assign out_side  = side[QBits];

endmodule

/* rtl/core/lcl_temperature_top.sv */
// Lifting condensation level temperature (Bolton), fully pipelined.
// Throughput one item per cycle while the output is not stalled.
// Depth is set by the 24 log2 squaring stages and the 18-stage restoring divider.
// The whole pipe holds on a stall at the output; nothing is dropped or repeated.
// Reset (rst, synchronous) clears all valid bits; payload registers are not reset.
// Depends on lcl_pkg, lcl_log2_pipe, lcl_div_pipe.
module lcl_temperature_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] air_temp, [31:16] dew_temp
  input  logic [1:0]  s_tuser,   // [0] air_temp_missing, [1] dew_temp_missing
  input  logic        s_tlast,   // last_point
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] lcl_temp
  output logic [1:0]  m_tuser,   // [0] lcl_missing, [1] lcl_saturated
  output logic        m_tlast    // last_out
);
  import lcl_pkg::*;

  // global advance: every stage moves when the output slot is free or drained
  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // ---- stage: kelvin conversion and missing check ----
  logic signed [16:0] air_s, dew_s;
  logic               miss_in;
  assign air_s   = 17'(signed'(s_tdata[15:0]));
  assign dew_s   = 17'(signed'(s_tdata[31:16]));
  assign miss_in = s_tuser[0] | s_tuser[1] | (air_s <= MinCelsius) | (dew_s <= MinCelsius);

  logic        k_vld;
  logic [15:0] k_tk, k_dk;
  log_pass_t   k_pass;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_vld <= 1'b0;
    end else if (adv) begin
      k_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k_tk        <= s_tdata[15:0] + KelvinOffset;
      k_dk        <= s_tdata[31:16] + KelvinOffset;
      k_pass.miss <= miss_in;
      k_pass.last <= s_tlast;
      k_pass.dk   <= s_tdata[31:16] + KelvinOffset;
    end
  end

  // ---- log2 of both temperatures ----
  logic        l_vld;
  logic [27:0] l_la, l_lb;
  log_pass_t   l_pass;

  lcl_log2_pipe u_log2 (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (k_vld),
    .in_a      (k_tk),
    .in_b      (k_dk),
    .in_pass   (k_pass),
    .out_valid (l_vld),
    .out_la    (l_la),
    .out_lb    (l_lb),
    .out_pass  (l_pass)
  );

  // ---- stage: log2 ratio times ln2 ----
  logic signed [28:0] l2;
  assign l2 = signed'({1'b0, l_la}) - signed'({1'b0, l_lb});

  logic               p_vld;
  logic signed [59:0] p_prod;
  log_pass_t          p_pass;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else if (adv) begin
      p_vld <= l_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_prod <= 60'(l2) * 60'(Ln2Q30);
      p_pass <= l_pass;
    end
  end

  // ---- stage: round to Q24, dh and numerator magnitude ----
  logic [59:0]        p_abs, p_rnd;
  logic signed [30:0] lnq_c;
  logic signed [17:0] dh_c;
  logic [16:0]        dh_abs;
  assign p_abs  = p_prod[59] ? 60'(-p_prod) : p_prod;
  assign p_rnd  = p_abs + (60'd1 << 29);
  assign lnq_c  = p_prod[59] ? -signed'({1'b0, p_rnd[59:30]}) : signed'({1'b0, p_rnd[59:30]});
  assign dh_c   = signed'({2'b0, p_pass.dk}) - BoltonB;
  assign dh_abs = dh_c[17] ? 17'(-dh_c) : dh_c[16:0];

  logic               n_vld;
  logic signed [30:0] n_lnq;
  logic signed [17:0] n_dh;
  logic [33:0]        n_mag;
  logic               n_miss, n_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_vld <= 1'b0;
    end else if (adv) begin
      n_vld <= p_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_lnq  <= lnq_c;
      n_dh   <= dh_c;
      n_mag  <= {17'd0, BoltonA} * {17'd0, dh_abs};
      n_miss <= p_pass.miss;
      n_last <= p_pass.last;
    end
  end

  // ---- stage: dh * ln ----
  logic               m_vld;
  logic signed [48:0] m_dhl;
  logic [33:0]        m_mag;
  logic               m_dneg, m_miss, m_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else if (adv) begin
      m_vld <= n_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_dhl  <= 49'(n_dh) * 49'(n_lnq);
      m_mag  <= n_mag;
      m_dneg <= n_dh[17];
      m_miss <= n_miss;
      m_last <= n_last;
    end
  end

  // ---- stage: denominator ----
  logic               d_vld;
  logic signed [63:0] d_den;
  logic [33:0]        d_mag;
  logic               d_nneg, d_miss, d_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else if (adv) begin
      d_vld <= m_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_den  <= BoltonAQ + 64'(m_dhl);
      d_mag  <= m_mag;
      d_nneg <= m_dneg;
      d_miss <= m_miss;
      d_last <= m_last;
    end
  end

  // ---- stage: divider operands, rounding folded in as (2n+d)/(2d) ----
  logic [63:0] den_abs;
  assign den_abs = d_den[63] ? 64'(-d_den) : d_den;

  logic        v_vld;
  logic [63:0] v_num, v_dsr;
  div_side_t   v_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_vld <= 1'b0;
    end else if (adv) begin
      v_vld <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      v_num       <= ({30'd0, d_mag} << 25) + den_abs;
      v_dsr       <= den_abs << 1;
      v_side.neg  <= d_nneg ^ d_den[63];
      v_side.miss <= d_miss | (d_den == '0);
      v_side.last <= d_last;
    end
  end

  // ---- quotient ----
  logic        q_vld, q_ovf;
  logic [16:0] q_q;
  div_side_t   q_side;

  lcl_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (v_vld),
    .in_num    (v_num),
    .in_dsr    (v_dsr),
    .in_side   (v_side),
    .out_valid (q_vld),
    .out_ovf   (q_ovf),
    .out_q     (q_q),
    .out_side  (q_side)
  );

  // ---- output register: offset, clamp, missing ----
  logic signed [18:0] r;
  logic [15:0]        val;
  logic               sat;
  assign r = q_side.neg ? 19'(BoltonB) - signed'({2'b0, q_q})
                        : 19'(BoltonB) + signed'({2'b0, q_q});

  always_comb begin
    val = '0;
    sat = 1'b0;
    if (q_side.miss) begin
      val = '0;
      sat = 1'b0;
    end else if (q_ovf) begin
      // magnitude at least 2^17: far outside either end
      val = q_side.neg ? 16'd0 : 16'hFFFF;
      sat = 1'b1;
    end else if (r < 0) begin
      val = '0;
      sat = 1'b1;
    end else if (r > 19'sd65535) begin
      val = 16'hFFFF;
      sat = 1'b1;
    end else begin
      val = r[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= q_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata    <= val;
      m_tuser[0] <= q_side.miss;
      m_tuser[1] <= sat;
      m_tlast    <= q_side.last;
    end
  end

endmodule

/* tb/tb_lcl_temperature_top.sv */
// Self-checking bench for lcl_temperature_top: streams grid points, predicts the
// Bolton LCL temperature in integer fixed point and compares each result transaction.
// Depends on lcl_pkg and the lcl_temperature_top RTL only.
module tb_lcl_temperature_top;
  import lcl_pkg::*;

  typedef struct packed {
    logic signed [15:0] air;
    logic               air_miss;
    logic signed [15:0] dew;
    logic               dew_miss;
    logic               last;
  } point_t;

  typedef struct packed {
    logic [15:0] lcl;
    logic        miss;
    logic        sat;
    logic        last;
  } lcl_res_t;

  localparam int PipeLatency = 50;
  localparam int CycleLimit  = 400000;
  localparam longint A_Q24   = 64'sd80000 <<< 24;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  point_t   point_queue[$];
  lcl_res_t lcl_expected[$];
  int       sender_idle_pct;
  int       recv_stall_pct;
  bit       holdoff_req;
  bit       holdoff_done;
  int       holdoff_left;
  int       errors;
  int       cycles;

  lcl_temperature_top u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // log2 in Q24: leading-one exponent, then 24 squaring steps on a Q30 mantissa
  function automatic longint log2_q24(input longint unsigned x);
    int              e;
    longint unsigned m;
    longint          r;
    e = 0;
    while (e < 31 && (x >> (e + 1)) != 0) e++;
    m = x << (30 - e);
    r = longint'(e) <<< 24;
    for (int i = 23; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        r += longint'(1) <<< i;
      end
    end
    return r;
  endfunction

  // nearest, ties away from zero
  function automatic longint round_div(input longint num, input longint den);
    longint unsigned n, d, q;
    bit              neg;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = (2 * n + d) / (2 * d);
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic lcl_res_t lcl_predict(input point_t p);
    lcl_res_t r;
    longint   tk, dk, l2, lnq, dh, den, num, q;
    r = '0;
    r.last = p.last;
    r.miss = p.air_miss || p.dew_miss || p.air <= -27315 || p.dew <= -27315;
    if (!r.miss) begin
      tk  = longint'(p.air) + 27315;
      dk  = longint'(p.dew) + 27315;
      l2  = log2_q24(tk) - log2_q24(dk);
      lnq = round_div(l2 * 744261118, longint'(1) <<< 30);
      dh  = dk - 5600;
      den = A_Q24 + dh * lnq;
      if (den == 0) begin
        r.miss = 1'b1;
      end else begin
        num = 80000 * dh * (longint'(1) <<< 24);
        q = round_div(num, den) + 5600;
        if (q < 0) begin
          r.sat = 1'b1;
        end else if (q > 65535) begin
          r.lcl = 16'hFFFF;
          r.sat = 1'b1;
        end else begin
          r.lcl = q[15:0];
        end
      end
    end
    return r;
  endfunction

  // Driver: predicts on each accepted transaction, then offers the next point.
  always @(posedge clk) begin
    point_t p;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= '0;
      s_tlast  <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        p.air = s_tdata[15:0];
        p.dew = s_tdata[31:16];
        p.air_miss = s_tuser[0];
        p.dew_miss = s_tuser[1];
        p.last = s_tlast;
        lcl_expected.push_back(lcl_predict(p));
      end
      if (!s_tvalid || s_tready) begin
        if (point_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          p = point_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {p.dew, p.air};
          s_tuser  <= {p.dew_miss, p.air_miss};
          s_tlast  <= p.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure plus one long hold-off; checks each result.
  always @(posedge clk) begin
    lcl_res_t e;
    if (rst) begin
      m_tready     <= 1'b0;
      holdoff_left <= 0;
      holdoff_done <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (lcl_expected.size() == 0) begin
          $error("result transaction with nothing expected");
          errors++;
        end else begin
          e = lcl_expected.pop_front();
          if (m_tdata !== e.lcl) begin
            $error("lcl_temp exp %0d got %0d", e.lcl, m_tdata);
            errors++;
          end
          if (m_tuser[0] !== e.miss) begin
            $error("lcl_missing exp %0d got %0d", e.miss, m_tuser[0]);
            errors++;
          end
          if (m_tuser[1] !== e.sat) begin
            $error("lcl_saturated exp %0d got %0d", e.sat, m_tuser[1]);
            errors++;
          end
          if (m_tlast !== e.last) begin
            $error("last_out exp %0d got %0d", e.last, m_tlast);
            errors++;
          end
        end
      end
      if (holdoff_req && !holdoff_done) begin
        holdoff_done <= 1'b1;
        holdoff_left <= 300;
        m_tready     <= 1'b0;
      end else if (holdoff_left > 0) begin
        holdoff_left <= holdoff_left - 1;
        m_tready     <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic point_t mk_point(input int air, input int dew,
                                      input bit am, input bit dm, input bit last);
    point_t p;
    p.air = air[15:0];
    p.dew = dew[15:0];
    p.air_miss = am;
    p.dew_miss = dm;
    p.last = last;
    return p;
  endfunction

  function automatic point_t rand_point();
    int air, dew, sel;
    sel = $urandom_range(99);
    if (sel < 60) begin
      // typical atmosphere, dewpoint at or below temperature
      air = $urandom_range(9000) - 5000;
      dew = air - int'($urandom_range(4000));
    end else if (sel < 85) begin
      air = $urandom_range(60081) - 27314;
      dew = $urandom_range(60081) - 27314;
    end else begin
      air = $urandom_range(65535) - 32768;
      dew = $urandom_range(65535) - 32768;
    end
    return mk_point(air, dew, $urandom_range(99) < 5, $urandom_range(99) < 5,
                    $urandom_range(15) == 0);
  endfunction

  task automatic run_phase(input int n, input int idle, input int stall);
    sender_idle_pct = idle;
    recv_stall_pct  = stall;
    repeat (n) point_queue.push_back(rand_point());
    wait (point_queue.size() == 0 && !s_tvalid && lcl_expected.size() == 0);
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    holdoff_req = 1'b0;
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, missing flags, absolute zero edge, saturation
    point_queue.push_back(mk_point(2000, 1000, 0, 0, 0));
    point_queue.push_back(mk_point(32767, 32767, 0, 0, 1));
    point_queue.push_back(mk_point(-32768, 0, 0, 0, 0));
    point_queue.push_back(mk_point(0, -32768, 0, 0, 0));
    point_queue.push_back(mk_point(-27315, 1000, 0, 0, 0));
    point_queue.push_back(mk_point(1000, -27315, 0, 0, 0));
    point_queue.push_back(mk_point(-27314, -27314, 0, 0, 0));
    point_queue.push_back(mk_point(32767, -27314, 0, 0, 0));
    point_queue.push_back(mk_point(-27314, 32767, 0, 0, 1));
    point_queue.push_back(mk_point(2500, 2500, 1, 0, 0));
    point_queue.push_back(mk_point(2500, 2500, 0, 1, 0));
    point_queue.push_back(mk_point(-1, -1, 1, 1, 1));
    point_queue.push_back(mk_point(0, 0, 0, 0, 0));
    point_queue.push_back(mk_point(-21715, -21715, 0, 0, 0)); // dewpoint at 56 K
    point_queue.push_back(mk_point(32767, -21800, 0, 0, 0));
    point_queue.push_back(mk_point(-27000, 32000, 0, 0, 0));
    point_queue.push_back(mk_point(3000, 3500, 0, 0, 0));
    point_queue.push_back(mk_point(-100, -32767, 0, 0, 1));
    run_phase(0, 0, 0);

    run_phase(300, 0, 0);
    run_phase(300, 45, 0);
    run_phase(300, 0, 45);
    run_phase(250, 14, 14);

    // long output hold-off while the sender keeps pushing
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    repeat (100) point_queue.push_back(rand_point());
    holdoff_req = 1'b1;
    wait (point_queue.size() == 0 && !s_tvalid && lcl_expected.size() == 0);

    repeat (PipeLatency + 10) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* lcl_temperature_top.f */
rtl/core/lcl_pkg.sv
rtl/core/lcl_log2_pipe.sv
rtl/core/lcl_div_pipe.sv
rtl/core/lcl_temperature_top.sv
tb/tb_lcl_temperature_top.sv
